// File: rtl/core/camera_point_projection_core_defines.svh
// Assertion macros shared by the projection core
`ifndef CAMERA_POINT_PROJECTION_CORE_DEFINES_SVH
`define CAMERA_POINT_PROJECTION_CORE_DEFINES_SVH

// same-cycle implication, sampled on clk, quiet during reset
`define CPP_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, quiet during reset
`define CPP_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/core/cpp_pkg.sv
// Types, constants and helpers of the camera point projection core
package cpp_pkg;

	// signed fixed point with 28 fraction bits, magnitude limited to 2^50 - 1
	typedef logic signed [51:0] q_t;

	localparam q_t QMAX = {2'b00, {50{1'b1}}};
	localparam q_t QONE = 52'sd268435456;

	localparam int IMAGE_WIDTH  = 2048;
	localparam int IMAGE_HEIGHT = 2048;
	localparam q_t LIM_X = q_t'(longint'(IMAGE_WIDTH - 1) * 64'sd268435456);
	localparam q_t LIM_Y = q_t'(longint'(IMAGE_HEIGHT - 1) * 64'sd268435456);
	localparam int PIX_W = 11;

	// register indexes
	localparam int CFG_IW = 4;
	localparam logic [CFG_IW-1:0] REG_K1    = 4'd0;
	localparam logic [CFG_IW-1:0] REG_K2    = 4'd1;
	localparam logic [CFG_IW-1:0] REG_K3    = 4'd2;
	localparam logic [CFG_IW-1:0] REG_P1    = 4'd3;
	localparam logic [CFG_IW-1:0] REG_P2    = 4'd4;
	localparam logic [CFG_IW-1:0] REG_FOCAL = 4'd5;
	localparam logic [CFG_IW-1:0] REG_PRINC = 4'd6;
	localparam logic [CFG_IW-1:0] REG_DEPTH = 4'd7;

	// divider geometry: 60-bit dividend, 32-bit divisor, two quotient bits a stage
	localparam int NUM_W      = 60;
	localparam int DEN_W      = 32;
	localparam int DIV_STAGES = NUM_W / 2;

	typedef struct packed {
		logic [15:0] idx;
		logic        neg_x;
		logic        neg_y;
		logic        ok;
	} div_side_t;

	// saturating add
	function automatic q_t sadd(q_t a, q_t b);
		logic signed [52:0] s;
		q_t r;
		s = 53'(a) + 53'(b);
		if (s > 53'(QMAX))
			r = QMAX;
		else if (s < -53'(QMAX))
			r = -QMAX;
		else
			r = q_t'(s);
		return r;
	endfunction

endpackage

// File: rtl/core/cpp_qmul.sv
// Three-stage fixed-point multiplier with truncation and saturation
module cpp_qmul import cpp_pkg::*; (
	input  logic clk,
	input  logic en,
	input  q_t   a,
	input  q_t   b,
	output q_t   p
);

	logic [50:0] ma_s1, mb_s1;
	logic        neg_s1, neg_s2;
	logic [51:0] pp_ll_s2;
	logic [50:0] pp_lh_s2, pp_hl_s2;
	logic [49:0] pp_hh_s2;
	q_t          p_s3;

	logic [51:0]  mid;
	logic [101:0] full;
	logic [73:0]  r;
	logic [50:0]  rm;

	always_comb begin
		mid  = 52'(pp_lh_s2) + 52'(pp_hl_s2);
		full = {pp_hh_s2, 52'b0} + {24'b0, mid, 26'b0} + {50'b0, pp_ll_s2};
		r    = full[101:28];
		rm   = (r > 74'(QMAX[50:0])) ? QMAX[50:0] : r[50:0];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			// magnitudes and sign
			ma_s1  <= a[51] ? 51'(-a) : a[50:0];
			mb_s1  <= b[51] ? 51'(-b) : b[50:0];
			neg_s1 <= a[51] ^ b[51];
			// partial products on the low 26-bit and high 25-bit halves
			pp_ll_s2 <= 26'(ma_s1[25:0]) * 26'(mb_s1[25:0]);
			pp_lh_s2 <= 51'(ma_s1[25:0]) * 51'(mb_s1[50:26]);
			pp_hl_s2 <= 51'(ma_s1[50:26]) * 51'(mb_s1[25:0]);
			pp_hh_s2 <= 50'(ma_s1[50:26]) * 50'(mb_s1[50:26]);
			neg_s2   <= neg_s1;
			// combine, drop 28 fraction bits, clamp, sign
			p_s3 <= neg_s2 ? -q_t'({1'b0, rm}) : q_t'({1'b0, rm});
		end
	end

	assign p = p_s3;

endmodule

// File: rtl/core/cpp_div.sv
// Pipelined restoring divider, two quotient bits per stage, shared divisor
module cpp_div import cpp_pkg::*; (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             en,
	input  logic             in_vld,
	input  div_side_t        in_side,
	input  logic [NUM_W-1:0] num_x,
	input  logic [NUM_W-1:0] num_y,
	input  logic [DEN_W-1:0] den,
	output logic             out_vld,
	output div_side_t        out_side,
	output logic [NUM_W-1:0] q_x,
	output logic [NUM_W-1:0] q_y
);

	logic             vld_s  [1:DIV_STAGES];
	div_side_t        side_s [1:DIV_STAGES];
	logic [DEN_W-1:0] den_s  [1:DIV_STAGES];
	logic [DEN_W-1:0] rx_s   [1:DIV_STAGES];
	logic [DEN_W-1:0] ry_s   [1:DIV_STAGES];
	logic [NUM_W-1:0] wx_s   [1:DIV_STAGES];
	logic [NUM_W-1:0] wy_s   [1:DIV_STAGES];

	// dividend bits shift out the top, quotient bits shift in at the bottom
	function automatic logic [DEN_W+NUM_W-1:0] div_step2(logic [DEN_W-1:0] rem,
			logic [NUM_W-1:0] w_in, logic [DEN_W-1:0] d);
		logic [DEN_W:0]   t;
		logic [DEN_W-1:0] rr;
		logic [NUM_W-1:0] w;
		rr = rem;
		w  = w_in;
		for (int i = 0; i < 2; i++) begin
			t = {rr, w[NUM_W-1]};
			w = {w[NUM_W-2:0], 1'b0};
			if (t >= {1'b0, d}) begin
				t    = t - {1'b0, d};
				w[0] = 1'b1;
			end
			rr = t[DEN_W-1:0];
		end
		return {rr, w};
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 1; k <= DIV_STAGES; k++)
				vld_s[k] <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_vld;
			for (int k = 2; k <= DIV_STAGES; k++)
				vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[1]         <= in_side;
			den_s[1]          <= den;
			{rx_s[1], wx_s[1]} <= div_step2('0, num_x, den);
			{ry_s[1], wy_s[1]} <= div_step2('0, num_y, den);
			for (int k = 2; k <= DIV_STAGES; k++) begin
				side_s[k]          <= side_s[k-1];
				den_s[k]           <= den_s[k-1];
				{rx_s[k], wx_s[k]} <= div_step2(rx_s[k-1], wx_s[k-1], den_s[k-1]);
				{ry_s[k], wy_s[k]} <= div_step2(ry_s[k-1], wy_s[k-1], den_s[k-1]);
			end
		end
	end

	assign out_vld  = vld_s[DIV_STAGES];
	assign out_side = side_s[DIV_STAGES];
	assign q_x      = wx_s[DIV_STAGES];
	assign q_y      = wy_s[DIV_STAGES];

endmodule

// File: rtl/core/camera_point_projection_core.sv
// Top level of the camera point projection core
//
// Use: points stream in on the s_axis channel, one word per point (index and
// camera-frame x, y, z in signed Q16.16). Each point gives exactly one word
// on m_axis: the index, the distorted pixel column and row truncated toward
// zero, and a hit flag on tuser. A miss (depth outside the window, depth zero,
// or pixel outside the image) returns zero pixels with hit low.
// Coefficients, focal lengths, principal point and depth window are written
// through the cfg channel (cfg_ready is always high); write them only while
// no point is in flight.
// Pipeline: one input register, 30 divider stages (two quotient bits each),
// then 25 levels of three-stage multipliers and saturating adds. Throughput:
// one point per cycle unless the output stalls.
// Stall: the pipeline advances as one; when the output word is held and not
// taken, every stage holds and s_axis_tready drops, so nothing is lost.
// Reset: valid bits and configuration registers clear; the data path is not reset.
`include "camera_point_projection_core_defines.svh"

module camera_point_projection_core import cpp_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// input point
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [111:0]      s_axis_tdata,   // point_index[15:0], cam_x[47:16], cam_y[79:48], cam_z[111:80]
	// projected pixel
	output logic              m_axis_tvalid,
	input  logic              m_axis_tready,
	output logic [39:0]       m_axis_tdata,   // index_out[15:0], pixel_x[26:16], pixel_y[37:27], zero pad
	output logic              m_axis_tuser,   // hit[0]
	// configuration
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_IW-1:0] cfg_index,
	input  logic [63:0]       cfg_data
);

	localparam int NL = 24;  // last level after the divider = output register

	// configuration
	logic [31:0] k1_q, k2_q, k3_q, p1_q, p2_q;
	logic [63:0] focal_q, princ_q, depth_q;

	// input register
	logic        vld_s0;
	logic [15:0] idx_s0;
	logic [31:0] x_s0, y_s0, z_s0;

	logic             pipe_en;
	logic             ok0;
	logic [31:0]      mx, my;
	div_side_t        side0, dv_side;
	logic             dv_vld;
	logic [NUM_W-1:0] qx, qy;

	// per-level control and index
	logic        vld_l [0:NL];
	logic        ok_l  [0:NL];
	logic [15:0] idx_l [0:NL];

	q_t k1q, k2q, k3q, p1q, p2q, fxq, fyq, cxq, cyq;
	q_t tx_l0, ty_l0;
	q_t txx, tyy, txy;
	q_t r2_l4, a2x_l4, a2y_l4, txy_l4;
	q_t r4, kr1, ptx, pty;
	q_t bx_l5, by_l5;
	q_t qbx, qby;
	q_t r6, kr2, kr3;
	q_t rad1_l8, tanx_l8, tany_l8;
	q_t rad2_l11, rad3_l14;
	q_t dxm, dym;
	q_t d1x_l18, d1y_l18, d2x_l19, d2y_l19;
	q_t uxm, uym, ux_l23, uy_l23;
	logic [PIX_W-1:0] px_l24, py_l24;
	logic             hit_l24;
	logic             hit_c;

	// alignment delays
	q_t r2_dl   [0:2];
	q_t rad1_dl [0:1];
	q_t rad2_dl [0:1];
	q_t tx_dl   [0:13];
	q_t ty_dl   [0:13];
	q_t tanx_dl [0:8];
	q_t tany_dl [0:8];
	q_t qbx_dl  [0:9];
	q_t qby_dl  [0:9];

	function automatic q_t div_sat(logic [NUM_W-1:0] q, logic neg);
		logic [50:0] m;
		m = (q > NUM_W'(QMAX[50:0])) ? QMAX[50:0] : q[50:0];
		return neg ? -q_t'({1'b0, m}) : q_t'({1'b0, m});
	endfunction

	// advance the whole pipe unless a finished word is waiting and not taken
	assign pipe_en       = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = pipe_en;
	assign cfg_ready     = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			k1_q    <= '0;
			k2_q    <= '0;
			k3_q    <= '0;
			p1_q    <= '0;
			p2_q    <= '0;
			focal_q <= '0;
			princ_q <= '0;
			depth_q <= '0;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_K1:    k1_q    <= cfg_data[31:0];
				REG_K2:    k2_q    <= cfg_data[31:0];
				REG_K3:    k3_q    <= cfg_data[31:0];
				REG_P1:    p1_q    <= cfg_data[31:0];
				REG_P2:    p2_q    <= cfg_data[31:0];
				REG_FOCAL: focal_q <= cfg_data;
				REG_PRINC: princ_q <= cfg_data;
				REG_DEPTH: depth_q <= cfg_data;
				default:   ;  // unknown index: drop the write
			endcase
		end
	end

	assign k1q = q_t'($signed(k1_q));
	assign k2q = q_t'($signed(k2_q));
	assign k3q = q_t'($signed(k3_q));
	assign p1q = q_t'($signed(p1_q));
	assign p2q = q_t'($signed(p2_q));
	assign fxq = q_t'({8'b0, focal_q[63:32], 12'b0});
	assign fyq = q_t'({8'b0, focal_q[31:0], 12'b0});
	assign cxq = q_t'({8'b0, princ_q[63:32], 12'b0});
	assign cyq = q_t'({8'b0, princ_q[31:0], 12'b0});

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			vld_s0 <= 1'b0;
		else if (pipe_en)
			vld_s0 <= s_axis_tvalid;
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			idx_s0 <= s_axis_tdata[15:0];
			x_s0   <= s_axis_tdata[47:16];
			y_s0   <= s_axis_tdata[79:48];
			z_s0   <= s_axis_tdata[111:80];
		end
	end

	// depth window: a negative depth always falls below the unsigned minimum
	always_comb begin
		ok0 = (z_s0 != 32'd0)
			&& ($signed({z_s0[31], z_s0}) >= $signed({1'b0, depth_q[63:32]}))
			&& ($signed({z_s0[31], z_s0}) <= $signed({1'b0, depth_q[31:0]}));
		mx = x_s0[31] ? 32'(-x_s0) : x_s0;
		my = y_s0[31] ? 32'(-y_s0) : y_s0;
		side0.idx   = idx_s0;
		side0.neg_x = x_s0[31];
		side0.neg_y = y_s0[31];
		side0.ok    = ok0;
	end

	// x and y over depth; the divisor is garbage on a miss and the result is dropped
	cpp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (pipe_en),
		.in_vld   (vld_s0),
		.in_side  (side0),
		.num_x    ({mx, 28'b0}),
		.num_y    ({my, 28'b0}),
		.den      (z_s0),
		.out_vld  (dv_vld),
		.out_side (dv_side),
		.q_x      (qx),
		.q_y      (qy)
	);

	// valid, hit-eligible and index travel level by level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= NL; k++)
				vld_l[k] <= 1'b0;
		end else if (pipe_en) begin
			vld_l[0] <= dv_vld;
			for (int k = 1; k <= NL; k++)
				vld_l[k] <= vld_l[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			ok_l[0]  <= dv_side.ok;
			idx_l[0] <= dv_side.idx;
			for (int k = 1; k <= NL; k++) begin
				ok_l[k]  <= ok_l[k-1];
				idx_l[k] <= idx_l[k-1];
			end
		end
	end

	// level 0: normalized coordinates, clamped and signed
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			tx_l0 <= div_sat(qx, dv_side.neg_x);
			ty_l0 <= div_sat(qy, dv_side.neg_y);
		end
	end

	// levels 0 -> 3: squares and cross term
	cpp_qmul u_txx (.clk(clk), .en(pipe_en), .a(tx_l0), .b(tx_l0), .p(txx));
	cpp_qmul u_tyy (.clk(clk), .en(pipe_en), .a(ty_l0), .b(ty_l0), .p(tyy));
	cpp_qmul u_txy (.clk(clk), .en(pipe_en), .a(tx_l0), .b(ty_l0), .p(txy));

	// levels 4 -> 7: r^4, k1 term, tangential cross terms
	cpp_qmul u_r4  (.clk(clk), .en(pipe_en), .a(r2_l4), .b(r2_l4),  .p(r4));
	cpp_qmul u_kr1 (.clk(clk), .en(pipe_en), .a(k1q),   .b(r2_l4),  .p(kr1));
	cpp_qmul u_ptx (.clk(clk), .en(pipe_en), .a(p1q),   .b(txy_l4), .p(ptx));
	cpp_qmul u_pty (.clk(clk), .en(pipe_en), .a(p2q),   .b(txy_l4), .p(pty));

	// levels 5 -> 8: tangential r2 + 2t^2 terms
	cpp_qmul u_qbx (.clk(clk), .en(pipe_en), .a(p2q), .b(bx_l5), .p(qbx));
	cpp_qmul u_qby (.clk(clk), .en(pipe_en), .a(p1q), .b(by_l5), .p(qby));

	// levels 7 -> 10: r^6 and k2 term
	cpp_qmul u_r6  (.clk(clk), .en(pipe_en), .a(r4),  .b(r2_dl[2]), .p(r6));
	cpp_qmul u_kr2 (.clk(clk), .en(pipe_en), .a(k2q), .b(r4),       .p(kr2));

	// levels 10 -> 13: k3 term
	cpp_qmul u_kr3 (.clk(clk), .en(pipe_en), .a(k3q), .b(r6), .p(kr3));

	// levels 14 -> 17: radial scaling
	cpp_qmul u_dx (.clk(clk), .en(pipe_en), .a(tx_dl[13]), .b(rad3_l14), .p(dxm));
	cpp_qmul u_dy (.clk(clk), .en(pipe_en), .a(ty_dl[13]), .b(rad3_l14), .p(dym));

	// levels 19 -> 22: focal lengths
	cpp_qmul u_ux (.clk(clk), .en(pipe_en), .a(fxq), .b(d2x_l19), .p(uxm));
	cpp_qmul u_uy (.clk(clk), .en(pipe_en), .a(fyq), .b(d2y_l19), .p(uym));

	// saturating add levels and alignment delays
	always_ff @(posedge clk) begin
		if (pipe_en) begin
			r2_l4  <= sadd(txx, tyy);
			a2x_l4 <= sadd(txx, txx);
			a2y_l4 <= sadd(tyy, tyy);
			txy_l4 <= txy;

			bx_l5 <= sadd(r2_l4, a2x_l4);
			by_l5 <= sadd(r2_l4, a2y_l4);

			rad1_l8 <= sadd(QONE, kr1);
			tanx_l8 <= sadd(ptx, ptx);
			tany_l8 <= sadd(pty, pty);

			rad2_l11 <= sadd(rad1_dl[1], kr2);
			rad3_l14 <= sadd(rad2_dl[1], kr3);

			d1x_l18 <= sadd(dxm, tanx_dl[8]);
			d1y_l18 <= sadd(dym, tany_dl[8]);
			d2x_l19 <= sadd(d1x_l18, qbx_dl[9]);
			d2y_l19 <= sadd(d1y_l18, qby_dl[9]);

			ux_l23 <= sadd(uxm, cxq);
			uy_l23 <= sadd(uym, cyq);

			r2_dl[0]   <= r2_l4;
			rad1_dl[0] <= rad1_l8;
			rad2_dl[0] <= rad2_l11;
			tx_dl[0]   <= tx_l0;
			ty_dl[0]   <= ty_l0;
			tanx_dl[0] <= tanx_l8;
			tany_dl[0] <= tany_l8;
			qbx_dl[0]  <= qbx;
			qby_dl[0]  <= qby;
			for (int k = 1; k < 3; k++)
				r2_dl[k] <= r2_dl[k-1];
			rad1_dl[1] <= rad1_dl[0];
			rad2_dl[1] <= rad2_dl[0];
			for (int k = 1; k < 14; k++) begin
				tx_dl[k] <= tx_dl[k-1];
				ty_dl[k] <= ty_dl[k-1];
			end
			for (int k = 1; k < 9; k++) begin
				tanx_dl[k] <= tanx_dl[k-1];
				tany_dl[k] <= tany_dl[k-1];
			end
			for (int k = 1; k < 10; k++) begin
				qbx_dl[k] <= qbx_dl[k-1];
				qby_dl[k] <= qby_dl[k-1];
			end
		end
	end

	// bounds check; a miss returns zero pixels
	assign hit_c = ok_l[NL-1]
		&& !ux_l23[51] && (ux_l23 <= LIM_X)
		&& !uy_l23[51] && (uy_l23 <= LIM_Y);

	always_ff @(posedge clk) begin
		if (pipe_en) begin
			hit_l24 <= hit_c;
			px_l24  <= hit_c ? ux_l23[28+PIX_W-1:28] : '0;
			py_l24  <= hit_c ? uy_l23[28+PIX_W-1:28] : '0;
		end
	end

	assign m_axis_tvalid = vld_l[NL];
	assign m_axis_tdata  = {2'b00, py_l24, px_l24, idx_l[NL]};
	assign m_axis_tuser  = hit_l24;

	`CPP_ASSERT_IMP(a_miss_zero_pixels, m_axis_tvalid && !m_axis_tuser, m_axis_tdata[37:16] == 22'd0, "miss word carries a nonzero pixel")
	`CPP_ASSERT_NXT(a_stall_holds_pipe, !pipe_en, $stable(dv_vld) && $stable(vld_l[0]) && $stable(vld_s0), "pipeline moved during a stall")
	`CPP_ASSERT_NXT(a_advance_delivers, pipe_en && vld_l[NL-1], m_axis_tvalid, "advanced word did not reach the output")

endmodule
